// File: rtl/bds2_pkg.sv
// Shared constants for the 2x2 box downsampler.
`default_nettype none
package bds2_pkg;

    localparam int unsigned DEFAULT_MAX_WIDTH = 1024;
    localparam int unsigned HEIGHT_LIMIT      = 1024;
    localparam int unsigned ROW_BITS          = 10;
    localparam int unsigned CFG_DATA_BITS     = 11;
    localparam int unsigned CFG_INDEX_BITS    = 2;
    localparam int unsigned CHAN_BITS         = 8;
    localparam int unsigned NUM_CHAN          = 4;
    localparam int unsigned PAIR_BITS         = CHAN_BITS + 1;
    localparam int unsigned QUAD_BITS         = CHAN_BITS + 2;
    localparam int unsigned PIXEL_BITS        = NUM_CHAN * CHAN_BITS;
    localparam int unsigned LINE_BITS         = NUM_CHAN * PAIR_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOUR_CHANNEL  = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 11'd1024;
    localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 11'd1024;
    localparam logic [CFG_DATA_BITS-1:0] MIN_SIZE     = 11'd2;

endpackage
`default_nettype wire

// File: rtl/bds2_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module bds2_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/box_downsample_2x2_top.sv
// Top level of the 2x2 box-filter image downsampler.
// Takes one source pixel per clock in raster order and emits one averaged pixel for each
// complete 2x2 block, on odd columns of odd rows; a trailing odd column or row yields
// nothing and o_m_tlast marks the last output pixel of the image. An emitting beat is
// loaded into the stage register when it is accepted and into the output register once
// that register is empty or being taken, which raises o_m_tvalid. The block takes one
// pixel per clock and stalls its input only while the stage register and the output
// register both hold a pixel that the sink has not taken.
// Even rows park their horizontal pair sums in a MAX_WIDTH/2 x 36 line RAM that odd
// rows read back. A write to the width, height or four-channel register restarts the
// frame; write registers only while the block is idle.
`default_nettype none
module box_downsample_2x2_top #(
    parameter int unsigned MAX_WIDTH = bds2_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // chan_a [7:0], chan_b [15:8], chan_c [23:16], chan_d [31:24]
    input  wire logic [bds2_pkg::PIXEL_BITS-1:0]     i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // out_a [7:0], out_b [15:8], out_c [23:16], out_d [31:24]
    output logic      [bds2_pkg::PIXEL_BITS-1:0]     o_m_tdata,
    output logic                                     o_m_tlast,
    input  wire logic                                i_cfg_we,
    input  wire logic [bds2_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [bds2_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned AW = $clog2(MAX_WIDTH / 2);
    localparam int unsigned DEPTH = MAX_WIDTH / 2;
    localparam int unsigned WW = (CW + 1 > bds2_pkg::CFG_DATA_BITS) ? CW + 1
                                                                   : bds2_pkg::CFG_DATA_BITS;
    localparam int unsigned RB = bds2_pkg::ROW_BITS;
    localparam int unsigned CB = bds2_pkg::CHAN_BITS;
    localparam int unsigned PB = bds2_pkg::PAIR_BITS;
    localparam int unsigned QB = bds2_pkg::QUAD_BITS;
    localparam int unsigned NC = bds2_pkg::NUM_CHAN;

    logic [bds2_pkg::CFG_DATA_BITS-1:0] r_src_w;
    logic [bds2_pkg::CFG_DATA_BITS-1:0] r_src_h;
    logic                               r_four;

    logic [CW-1:0]                      r_col;
    logic [RB-1:0]                      r_row;
    logic [bds2_pkg::PIXEL_BITS-1:0]    r_hold;

    logic                               r_s1_valid;
    logic                               r_s1_last;
    logic [bds2_pkg::LINE_BITS-1:0]     r_s1_ps;

    logic                               r_out_valid;
    logic                               r_out_last;
    logic [bds2_pkg::PIXEL_BITS-1:0]    r_out_data;

    logic [WW-1:0]                      w_ext;
    logic [CW:0]                        eff_w;
    logic [bds2_pkg::CFG_DATA_BITS-1:0] eff_h;
    logic [CW-1:0]                      pair_w;
    logic [RB-1:0]                      pair_h;
    logic [CW-1:0]                      idx_full;
    logic [AW-1:0]                      idx;
    logic                               col_last;
    logic                               row_last;
    logic                               in_range;
    logic                               final_now;
    logic                               cfg_hit;
    logic                               accept;
    logic                               s1_move;
    logic                               emit_now;
    logic                               store_now;
    logic [bds2_pkg::PIXEL_BITS-1:0]    pix;
    logic [bds2_pkg::LINE_BITS-1:0]     ps;
    logic [bds2_pkg::LINE_BITS-1:0]     line_rdata;
    logic [bds2_pkg::PIXEL_BITS-1:0]    n_out_data;

    // Effective frame size
    always_comb begin
        w_ext = WW'(r_src_w);
        if (r_src_w < bds2_pkg::MIN_SIZE) begin
            eff_w = (CW + 1)'(2);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            eff_w = (CW + 1)'(MAX_WIDTH);
        end else begin
            eff_w = w_ext[CW:0];
        end
        if (r_src_h < bds2_pkg::MIN_SIZE) begin
            eff_h = bds2_pkg::MIN_SIZE;
        end else if (r_src_h > bds2_pkg::CFG_DATA_BITS'(bds2_pkg::HEIGHT_LIMIT)) begin
            eff_h = bds2_pkg::CFG_DATA_BITS'(bds2_pkg::HEIGHT_LIMIT);
        end else begin
            eff_h = r_src_h;
        end
    end

    assign pair_w   = eff_w[CW:1];
    assign pair_h   = eff_h[RB:1];
    assign idx_full = r_col >> 1;
    assign idx      = idx_full[AW-1:0];
    assign col_last = ({1'b0, r_col} + 1'b1) >= eff_w;
    assign row_last = ({1'b0, r_row} + 1'b1) >= eff_h;
    assign in_range = (idx_full < pair_w) && ({1'b0, r_row[RB-1:1]} < pair_h);
    assign final_now = r_row[0] && ({1'b0, r_row[RB-1:1]} == (pair_h - 1'b1))
                       && (idx_full == (pair_w - 1'b1));

    assign cfg_hit = i_cfg_we && ((i_cfg_index == bds2_pkg::CFG_SOURCE_WIDTH)
                     || (i_cfg_index == bds2_pkg::CFG_SOURCE_HEIGHT)
                     || (i_cfg_index == bds2_pkg::CFG_FOUR_CHANNEL));

    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;
    assign accept     = i_s_tvalid && o_s_tready;
    assign emit_now   = accept && r_col[0] && r_row[0] && in_range;
    assign store_now  = accept && r_col[0] && !r_row[0] && in_range;

    // Drop the fourth channel in three-channel mode
    assign pix = {(r_four ? i_s_tdata[4*CB-1:3*CB] : CB'(0)), i_s_tdata[3*CB-1:0]};

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            ps[i*PB +: PB] = {1'b0, r_hold[i*CB +: CB]} + {1'b0, pix[i*CB +: CB]};
        end
    end

    bds2_ram #(
        .WIDTH(bds2_pkg::LINE_BITS),
        .DEPTH(DEPTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (store_now),
        .i_waddr(idx),
        .i_wdata(ps),
        .i_re   (emit_now),
        .i_raddr(idx),
        .o_rdata(line_rdata)
    );

    always_comb begin
        logic [QB-1:0] sum;
        sum = '0;
        for (int i = 0; i < NC; i++) begin
            sum = {1'b0, r_s1_ps[i*PB +: PB]} + {1'b0, line_rdata[i*PB +: PB]};
            n_out_data[i*CB +: CB] = sum[QB-1:2];
        end
        if (!r_four) begin
            n_out_data[4*CB-1:3*CB] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= bds2_pkg::RESET_WIDTH;
            r_src_h     <= bds2_pkg::RESET_HEIGHT;
            r_four      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_hold      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bds2_pkg::CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                    bds2_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                    bds2_pkg::CFG_FOUR_CHANNEL:  r_four  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_col  <= '0;
                r_row  <= '0;
                r_hold <= '0;
            end else if (accept) begin
                if (!r_col[0]) begin
                    r_hold <= pix;
                end
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (accept) begin
                r_s1_valid <= emit_now;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_s1_ps   <= ps;
            r_s1_last <= final_now;
        end
        if (s1_move) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTH
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < eff_w))
        else $error("column counter beyond frame width");

    a_emit_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_now |=> r_s1_valid)
        else $error("emitting beat lost before stage one");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |=> (r_s1_valid && $stable(r_s1_ps)))
        else $error("stage one dropped while output stalled");

    a_no_dual_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store_now && emit_now))
        else $error("line store read and write on one beat");
`endif

endmodule
`default_nettype wire
